// File: rtl/lifo_pkg.sv
// ============================================================================
// lifo_pkg: shared types and constants for the bounded LIFO stack
// Sizes of the entry store, command and status codes, and the structs that
// run between the stack controller and the top level.
// ============================================================================
`default_nettype none

package lifo_pkg;

    // Store geometry
    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND  = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    // Store access request from the controller
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    // One result item
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] data;
        logic [IDX_W-1:0]  found_index;
        logic [CNT_W-1:0]  element_count;
        logic              is_empty;
        logic              is_full;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/lifo_ram.sv
// ============================================================================
// lifo_ram: simple dual-port synchronous RAM
// One write port and one read port; read data registered.
// Contents are undefined until written.
// ============================================================================
`default_nettype none

module lifo_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/lifo_ctrl.sv
// ============================================================================
// lifo_ctrl: stack pointer, command sequencer and result register
// Decodes each request, drives the entry store, scans live entries for find
// and holds the finished result until the downstream side takes it.
// ============================================================================
`default_nettype none

module lifo_ctrl
    import lifo_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              cfg_wr_en,
    input  wire logic [CNT_W-1:0]  cfg_wr_data,
    // request side
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire logic [CMD_W-1:0]  req_cmd,
    input  wire logic [DATA_W-1:0] req_value,
    // result side
    output logic                   res_valid,
    input  wire logic              res_ready,
    output result_t                res,
    // entry store
    output ram_req_t               ram_req,
    input  wire logic [DATA_W-1:0] ram_rd_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CAP_MIN = CNT_W'(1);

    // clamp a capacity write into 1..DEPTH
    function automatic logic [CNT_W-1:0] sat_capacity(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = CAP_MIN;
        end
        else if (v > CAP_MAX)
        begin
            r = CAP_MAX;
        end
        return r;
    endfunction

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  top_reg, top_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic              accept;
    logic              empty;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  top_dec;
    logic              ld;
    logic [STAT_W-1:0] ld_status;
    logic [DATA_W-1:0] ld_data;
    logic [IDX_W-1:0]  ld_fidx;

    // take a request only when idle and the result slot is empty or frees this cycle
    assign req_ready = (state_reg == ST_IDLE) && (!out_valid_reg || res_ready);
    assign accept    = req_valid && req_ready;
    assign empty     = (top_reg >= cap_reg);
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign top_dec   = top_reg - CNT_W'(1);

    // command sequencing
    always_comb
    begin
        state_next      = state_reg;
        top_next        = top_reg;
        cap_next        = cap_reg;
        idx_next        = idx_reg;
        value_next      = value_reg;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = top_dec[ADDR_W-1:0];
        ram_req.wr_data = req_value;
        ram_req.rd_addr = top_reg[ADDR_W-1:0];
        ld              = 1'b0;
        ld_status       = STAT_OK;
        ld_data         = '0;
        ld_fidx         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_cmd)
                        CMD_PUSH:
                        begin
                            ld = 1'b1;
                            if (top_reg == '0)
                            begin
                                ld_status = STAT_FULL;
                            end
                            else
                            begin
                                ram_req.wr_en = 1'b1;
                                top_next      = top_dec;
                            end
                        end
                        CMD_POP, CMD_PEEK:
                        begin
                            if (empty)
                            begin
                                ld        = 1'b1;
                                ld_status = STAT_EMPTY;
                            end
                            else
                            begin
                                // top entry arrives next cycle
                                state_next = ST_READ;
                                if (req_cmd == CMD_POP)
                                begin
                                    top_next = top_reg + CNT_W'(1);
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            ld       = 1'b1;
                            top_next = cap_reg;
                        end
                        CMD_FIND:
                        begin
                            if (empty)
                            begin
                                ld        = 1'b1;
                                ld_status = STAT_NOTFOUND;
                            end
                            else
                            begin
                                // start at the top entry, walk toward capacity
                                state_next = ST_SCAN;
                                idx_next   = top_reg;
                                value_next = req_value;
                            end
                        end
                        default:
                        begin
                            ld = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                ld         = 1'b1;
                ld_data    = ram_rd_data;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                // data for idx_reg is on the read port; fetch the next entry
                ram_req.rd_addr = idx_inc[ADDR_W-1:0];
                if (ram_rd_data == value_reg)
                begin
                    ld         = 1'b1;
                    ld_fidx    = idx_reg[IDX_W-1:0];
                    state_next = ST_IDLE;
                end
                else if (idx_inc >= cap_reg)
                begin
                    ld         = 1'b1;
                    ld_status  = STAT_NOTFOUND;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // capacity write empties the stack
        if (cfg_wr_en)
        begin
            cap_next = sat_capacity(cfg_wr_data);
            top_next = cap_next;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (ld)
        begin
            out_valid_next         = 1'b1;
            out_next.status        = ld_status;
            out_next.data          = ld_data;
            out_next.found_index   = ld_fidx;
            out_next.element_count = cap_next - top_next;
            out_next.is_empty      = (top_next >= cap_next);
            out_next.is_full       = (top_next == '0);
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_reg       <= CAP_MAX;
            cap_reg       <= CAP_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        value_reg <= value_next;
        out_reg   <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire

// File: rtl/bounded_lifo_stack_with_search.sv
// ============================================================================
// bounded_lifo_stack_with_search: LIFO stack of unsigned 32-bit words with search
// Stack entries live in a synchronous RAM filled from the top of the
// configured capacity downward; find scans live entries from low index up.
// ============================================================================
//
//  channel   dir  handshake           payload
//  --------  ---  ------------------  ----------------------------------------
//  s_*       in   s_tvalid/s_tready   tuser: command; tdata: value
//  m_*       out  m_tvalid/m_tready   tuser: status; tdata: data, found_index,
//                                     element_count, is_empty, is_full
//  cfg_*     in   cfg_wr_en           cfg_wr_data: capacity
//
//  Push, clear, unused codes and refused requests are answered from the idle state.
//  Pop and peek: the top entry comes back through the registered RAM read port.
//  Find: answered from the idle state on an empty stack, else scans live
//  entries, one RAM read per cycle; s_tready stays low during the scan.
//  s_tready also drops while a finished result waits and m_tready is low.
//  After reset the stack is empty with capacity 256; no clearing pass.
//
`default_nettype none

module bounded_lifo_stack_with_search
    import lifo_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // capacity register
    input  wire logic              cfg_wr_en,
    input  wire logic [CNT_W-1:0]  cfg_wr_data,
    // request stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,   // [31:0] value
    input  wire logic [CMD_W-1:0]  s_tuser,   // [2:0] command
    // result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [55:0]            m_tdata,   // [31:0] data, [39:32] found_index,
                                              // [48:40] element_count,
                                              // [49] is_empty, [50] is_full
    output logic [STAT_W-1:0]      m_tuser    // [1:0] status
);

    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_rd_data;
    result_t           res;

    lifo_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_cmd     (s_tuser),
        .req_value   (s_tdata),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data)
    );

    lifo_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    // result packing
    assign m_tuser = res.status;
    assign m_tdata = {5'b0, res.is_full, res.is_empty, res.element_count,
                      res.found_index, res.data};

endmodule

`default_nettype wire
